// File: src/ucds_pkg.sv
// ucds_pkg: shared types and constants for the configuration descriptor scanner
// holds the transaction structs, descriptor codes and end reason codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ucds_pkg;

    localparam logic [7:0]  TYPE_INTERFACE = 8'h04;
    localparam logic [7:0]  TYPE_ENDPOINT  = 8'h05;
    localparam logic [7:0]  DIR_IN_BIT     = 8'h80;
    localparam logic [7:0]  HID_CLASS      = 8'd3;
    localparam logic [7:0]  KBD_PROTOCOL   = 8'd1;
    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        REASON_FOUND       = 2'd0,
        REASON_ZERO_LENGTH = 2'd1,
        REASON_TOTAL_LEN   = 2'd2,
        REASON_STREAM_END  = 2'd3
    } end_reason_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } scan_in_t;

    typedef struct packed {
        logic        found;
        end_reason_t end_reason;
        logic [7:0]  interface_number;
        logic [7:0]  endpoint_address;
        logic [15:0] max_packet_size;
    } scan_out_t;

endpackage

`default_nettype wire

// File: src/usb_config_descriptor_scan.sv
// usb_config_descriptor_scan: walks a configuration descriptor block byte by byte
// and reports the first keyboard interface IN endpoint; depends on ucds_pkg
//
//  channel   direction  payload      handshake
//  item      in         scan_in_t    item_valid / item_ready
//  result    out        scan_out_t   result_valid / result_ready
//
// one byte per cycle while item_ready is high; each accepted byte updates the registered parse state
// a result appears in the output register the cycle after the byte that ends the scan
// item_ready drops only while a result waits and the scan has not already ended
// rst_n clears all parse state and the output register
`timescale 1ns / 1ps
`default_nettype none

module usb_config_descriptor_scan
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire ucds_pkg::scan_in_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output ucds_pkg::scan_out_t      result
);

    import ucds_pkg::*;

    logic [15:0] byte_offset_reg,   byte_offset_next;
    logic [15:0] next_desc_reg,     next_desc_next;
    logic [15:0] total_length_reg,  total_length_next;
    logic [7:0]  desc_length_reg,   desc_length_next;
    logic [7:0]  desc_type_reg,     desc_type_next;
    logic        kbd_active_reg,    kbd_active_next;
    logic [7:0]  class_seen_reg,    class_seen_next;
    logic [7:0]  intf_capture_reg,  intf_capture_next;
    logic [7:0]  ep_capture_reg,    ep_capture_next;
    logic [7:0]  psize_low_reg,     psize_low_next;
    logic        scan_done_reg,     scan_done_next;
    logic        result_valid_reg,  result_valid_next;
    scan_out_t   result_reg,        result_next;

    logic        accept;
    logic        finish;
    logic        hit;
    end_reason_t reason;
    logic [15:0] mps;
    logic [15:0] room;
    logic [15:0] remaining;
    logic [7:0]  rel;
    logic [15:0] start;
    logic [7:0]  b;
    logic [15:0] off;

    assign item_ready   = !result_valid_reg || result_ready || scan_done_reg;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        b         = item.data_byte;
        off       = byte_offset_reg;
        room      = OFFSET_MAX - off;
        remaining = next_desc_reg - off;
        rel       = desc_length_reg - remaining[7:0];

        byte_offset_next  = byte_offset_reg;
        next_desc_next    = next_desc_reg;
        total_length_next = total_length_reg;
        desc_length_next  = desc_length_reg;
        desc_type_next    = desc_type_reg;
        kbd_active_next   = kbd_active_reg;
        class_seen_next   = class_seen_reg;
        intf_capture_next = intf_capture_reg;
        ep_capture_next   = ep_capture_reg;
        psize_low_next    = psize_low_reg;
        scan_done_next    = scan_done_reg;
        start             = 16'd0;

        finish = 1'b0;
        hit    = 1'b0;
        reason = REASON_FOUND;
        mps    = 16'd0;

        if (!scan_done_reg)
        begin
            if (off == 16'd2)
            begin
                total_length_next[7:0] = b;
            end
            else if (off == 16'd3)
            begin
                total_length_next[15:8] = b;
            end

            if (off == next_desc_reg)
            begin
                if (off >= 16'd4 && off >= total_length_next)
                begin
                    finish = 1'b1;
                    reason = REASON_TOTAL_LEN;
                end
                else if (b == 8'd0)
                begin
                    desc_length_next = 8'd0;
                    if (off >= 16'd4)
                    begin
                        finish = 1'b1;
                        reason = REASON_ZERO_LENGTH;
                    end
                end
                else
                begin
                    desc_length_next = ({8'd0, b} < room) ? b : room[7:0];
                    next_desc_next   = off + {8'd0, desc_length_next};
                    desc_type_next   = 8'd0;
                end
            end
            else if (desc_length_reg != 8'd0 && off < next_desc_reg)
            begin
                if (rel == 8'd1)
                begin
                    desc_type_next = b;
                    if (b == TYPE_INTERFACE)
                    begin
                        kbd_active_next = 1'b0;
                        class_seen_next = 8'd0;
                    end
                end
                else if (desc_type_reg == TYPE_INTERFACE)
                begin
                    if (rel == 8'd2)
                    begin
                        intf_capture_next = b;
                    end
                    else if (rel == 8'd5)
                    begin
                        class_seen_next = b;
                    end
                    else if (rel == 8'd7)
                    begin
                        kbd_active_next = (class_seen_reg == HID_CLASS) && (b == KBD_PROTOCOL);
                    end
                end
                else if (desc_type_reg == TYPE_ENDPOINT)
                begin
                    if (rel == 8'd2 && kbd_active_reg && (b & DIR_IN_BIT) != 8'd0)
                    begin
                        ep_capture_next = b;
                        psize_low_next  = 8'd0;
                    end
                    else if (rel == 8'd4 && ep_capture_reg != 8'd0)
                    begin
                        psize_low_next = b;
                    end
                    if (ep_capture_next != 8'd0 && rel >= 8'd2 &&
                        (rel == 8'd5 || ({1'b0, rel} + 9'd1) == {1'b0, desc_length_reg}))
                    begin
                        finish = 1'b1;
                        hit    = 1'b1;
                        mps    = {(rel == 8'd5) ? b : 8'd0, psize_low_next};
                    end
                end
            end

            if (!finish && off == 16'd3)
            begin
                start = next_desc_next - {8'd0, desc_length_next};
                if (start >= total_length_next)
                begin
                    finish = 1'b1;
                    reason = REASON_TOTAL_LEN;
                end
                else if (desc_length_next == 8'd0)
                begin
                    finish = 1'b1;
                    reason = REASON_ZERO_LENGTH;
                end
            end

            if (!finish && item.last_byte)
            begin
                finish = 1'b1;
                if (ep_capture_next != 8'd0)
                begin
                    hit = 1'b1;
                    mps = {8'd0, psize_low_next};
                end
                else
                begin
                    reason = REASON_STREAM_END;
                end
            end

            if (finish)
            begin
                scan_done_next = 1'b1;
            end

            if (byte_offset_reg != OFFSET_MAX)
            begin
                byte_offset_next = byte_offset_reg + 16'd1;
            end
        end

        result_next.found            = hit;
        result_next.end_reason       = hit ? REASON_FOUND : reason;
        result_next.interface_number = hit ? intf_capture_next : 8'd0;
        result_next.endpoint_address = hit ? ep_capture_next : 8'd0;
        result_next.max_packet_size  = hit ? mps : 16'd0;

        if (item.last_byte)
        begin
            byte_offset_next  = 16'd0;
            next_desc_next    = 16'd0;
            total_length_next = 16'd0;
            desc_length_next  = 8'd0;
            desc_type_next    = 8'd0;
            kbd_active_next   = 1'b0;
            class_seen_next   = 8'd0;
            intf_capture_next = 8'd0;
            ep_capture_next   = 8'd0;
            psize_low_next    = 8'd0;
            scan_done_next    = 1'b0;
        end

        result_valid_next = result_valid_reg && !result_ready;
        if (accept && finish)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= '0;
            next_desc_reg    <= '0;
            total_length_reg <= '0;
            desc_length_reg  <= '0;
            desc_type_reg    <= '0;
            kbd_active_reg   <= 1'b0;
            class_seen_reg   <= '0;
            intf_capture_reg <= '0;
            ep_capture_reg   <= '0;
            psize_low_reg    <= '0;
            scan_done_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                byte_offset_reg  <= byte_offset_next;
                next_desc_reg    <= next_desc_next;
                total_length_reg <= total_length_next;
                desc_length_reg  <= desc_length_next;
                desc_type_reg    <= desc_type_next;
                kbd_active_reg   <= kbd_active_next;
                class_seen_reg   <= class_seen_next;
                intf_capture_reg <= intf_capture_next;
                ep_capture_reg   <= ep_capture_next;
                psize_low_reg    <= psize_low_next;
                scan_done_reg    <= scan_done_next;
            end
        end
    end

    // result payload, loaded only when a transaction ends the scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (accept && finish)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for usb_config_descriptor_scan
// drives descriptor blocks byte by byte and checks every result against a local scan predictor
// depends on ucds_pkg and usb_config_descriptor_scan
`timescale 1ns / 1ps

module testbench;

    import ucds_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int PRINT_LIMIT    = 40;

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    scan_in_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    scan_out_t result;

    usb_config_descriptor_scan u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // local copy of the scan state
    logic [15:0] pos;
    logic [15:0] desc_end;
    logic [15:0] block_total;
    logic [7:0]  desc_len;
    logic [7:0]  desc_kind;
    logic        kbd_mark;
    logic [7:0]  class_seen;
    logic [7:0]  intf_num;
    logic [7:0]  ep_addr;
    logic [7:0]  mps_low;
    logic        done;

    scan_out_t   expected_results[$];
    logic [7:0]  block_bytes[$];

    int mismatches      = 0;
    int results_checked = 0;
    int keyboards_found = 0;
    int live_items      = 0;
    int items_sent      = 0;
    int blocks_sent     = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;

    logic hold_request = 1'b0;
    int   hold_left    = 0;
    int   stall_mode   = 0;
    int   phase_left   = 0;
    int   tick         = 0;

    task automatic clear_scan_state();
        pos         = '0;
        desc_end    = '0;
        block_total = '0;
        desc_len    = '0;
        desc_kind   = '0;
        kbd_mark    = 1'b0;
        class_seen  = '0;
        intf_num    = '0;
        ep_addr     = '0;
        mps_low     = '0;
        done        = 1'b0;
    endtask

    initial clear_scan_state();

    task automatic predict_scan(input scan_in_t it);
        logic [7:0]  b;
        int unsigned off;
        int unsigned rel;
        int unsigned start;
        int unsigned room;
        bit          finish;
        bit          hit;
        end_reason_t why;
        logic [15:0] mps;
        scan_out_t   res;
        b      = it.data_byte;
        off    = pos;
        finish = 1'b0;
        hit    = 1'b0;
        why    = REASON_FOUND;
        mps    = '0;
        if (done)
        begin
            if (it.last_byte)
                clear_scan_state();
            return;
        end
        live_items++;
        if (off == 2)
            block_total[7:0] = b;
        else if (off == 3)
            block_total[15:8] = b;

        if (off == desc_end)
        begin
            if (off >= 4 && off >= block_total)
            begin
                finish = 1'b1;
                why    = REASON_TOTAL_LEN;
            end
            else if (b == 8'h00)
            begin
                desc_len = '0;
                if (off >= 4)
                begin
                    finish = 1'b1;
                    why    = REASON_ZERO_LENGTH;
                end
            end
            else
            begin
                room      = OFFSET_MAX - off;
                desc_len  = (b < room) ? b : 8'(room);
                desc_end  = 16'(off + desc_len);
                desc_kind = '0;
            end
        end
        else if (desc_len != 0 && off < desc_end)
        begin
            rel = desc_len - (desc_end - off);
            if (rel == 1)
            begin
                desc_kind = b;
                if (b == TYPE_INTERFACE)
                begin
                    kbd_mark   = 1'b0;
                    class_seen = '0;
                end
            end
            else if (desc_kind == TYPE_INTERFACE)
            begin
                if (rel == 2)
                    intf_num = b;
                else if (rel == 5)
                    class_seen = b;
                else if (rel == 7)
                    kbd_mark = (class_seen == HID_CLASS && b == KBD_PROTOCOL);
            end
            else if (desc_kind == TYPE_ENDPOINT)
            begin
                if (rel == 2 && kbd_mark && (b & DIR_IN_BIT) != 0)
                begin
                    ep_addr = b;
                    mps_low = '0;
                end
                else if (rel == 4 && ep_addr != 0)
                    mps_low = b;
                if (ep_addr != 0 && rel >= 2 && (rel == 5 || rel + 1 == desc_len))
                begin
                    finish = 1'b1;
                    hit    = 1'b1;
                    mps    = {(rel == 5) ? b : 8'h00, mps_low};
                end
            end
        end

        // starts at offsets 0 to 3 are judged once the total is complete
        if (!finish && off == 3)
        begin
            start = desc_end - desc_len;
            if (start >= block_total)
            begin
                finish = 1'b1;
                why    = REASON_TOTAL_LEN;
            end
            else if (desc_len == 0)
            begin
                finish = 1'b1;
                why    = REASON_ZERO_LENGTH;
            end
        end

        if (!finish && it.last_byte)
        begin
            finish = 1'b1;
            if (ep_addr != 0)
            begin
                hit = 1'b1;
                mps = {8'h00, mps_low};
            end
            else
                why = REASON_STREAM_END;
        end

        if (finish)
        begin
            res.found            = hit;
            res.end_reason       = hit ? REASON_FOUND : why;
            res.interface_number = hit ? intf_num : 8'h00;
            res.endpoint_address = hit ? ep_addr : 8'h00;
            res.max_packet_size  = hit ? mps : 16'h0000;
            expected_results.push_back(res);
            done = 1'b1;
        end

        if (pos != OFFSET_MAX)
            pos++;
        if (it.last_byte)
            clear_scan_state();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch on %s: got %0h expected %0h at result %0d",
                     what, got, want, results_checked);
    endtask

    task automatic check_result(input scan_out_t got);
        scan_out_t want;
        results_checked++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with none pending", 32'(got.end_reason), 32'd0);
            return;
        end
        want = expected_results.pop_front();
        if (want.found)
            keyboards_found++;
        if (got.found !== want.found)
            report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.end_reason !== want.end_reason)
            report_mismatch("end_reason", 32'(got.end_reason), 32'(want.end_reason));
        if (got.interface_number !== want.interface_number)
            report_mismatch("interface_number", 32'(got.interface_number),
                            32'(want.interface_number));
        if (got.endpoint_address !== want.endpoint_address)
            report_mismatch("endpoint_address", 32'(got.endpoint_address),
                            32'(want.endpoint_address));
        if (got.max_packet_size !== want.max_packet_size)
            report_mismatch("max_packet_size", 32'(got.max_packet_size),
                            32'(want.max_packet_size));
    endtask

    // transaction monitor, result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                check_result(result);
            if (item_valid && item_ready)
                predict_scan(item);
            if ((result_valid && result_ready) || (item_valid && item_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no transaction for %0d cycles", idle_cycles);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (phase_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 200);
        end
        else
            phase_left--;
        if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       result_ready <= 1'b1;
                1:       result_ready <= 1'($urandom_range(0, 1));
                2:       result_ready <= (tick % 5 == 0);
                default: result_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
        tick++;
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        item       <= '{data_byte: b, last_byte: l};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(10, 24);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end
    endtask

    task automatic send_block(input bit with_last);
        blocks_sent++;
        foreach (block_bytes[i])
            send_byte(block_bytes[i], with_last && (i == block_bytes.size() - 1));
    endtask

    task automatic add_descriptor(input int len, input logic [7:0] kind, f2, f3, f4, f5, f6,
                                  f7, f8);
        logic [7:0] fields [9];
        fields = '{8'(len), kind, f2, f3, f4, f5, f6, f7, f8};
        for (int i = 0; i < len || i == 0; i++)
            block_bytes.push_back((i < 9) ? fields[i] : 8'($urandom));
    endtask

    task automatic make_config_block();
        int          len;
        int          cut;
        logic [7:0]  cls;
        logic [7:0]  proto;
        logic [15:0] mps;
        logic [15:0] total;
        block_bytes.delete();
        add_descriptor(9, 8'h02, 8'h00, 8'h00, 8'($urandom_range(1, 3)), 8'h01, 8'h00, 8'hA0,
                       8'h32);
        repeat ($urandom_range(1, 3))
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                cls   = HID_CLASS;
                proto = KBD_PROTOCOL;
            end
            else
            begin
                cls   = $urandom_range(0, 1) ? HID_CLASS : 8'($urandom);
                proto = 8'($urandom_range(0, 2));
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 9;
            add_descriptor(len, TYPE_INTERFACE, 8'($urandom), 8'h00, 8'($urandom_range(1, 3)),
                           cls, 8'($urandom_range(0, 1)), proto, 8'h00);
            if ($urandom_range(0, 1))
                add_descriptor(9, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'($urandom), 8'h00);
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 5))
                    0:       mps = 16'hFFFF;
                    1:       mps = 16'($urandom);
                    default: mps = 16'($urandom_range(0, 64));
                endcase
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 7;
                add_descriptor(len, TYPE_ENDPOINT, 8'($urandom), 8'h03, mps[7:0], mps[15:8],
                               8'($urandom_range(1, 16)), 8'h00, 8'h00);
            end
            if ($urandom_range(0, 19) == 0)
                block_bytes.push_back(8'h00);
        end
        case ($urandom_range(0, 9))
            0:       total = 16'($urandom_range(0, 8));
            1:       total = 16'($urandom_range(0, block_bytes.size()));
            2:       total = 16'(block_bytes.size() + $urandom_range(1, 300));
            default: total = 16'(block_bytes.size());
        endcase
        block_bytes[2] = total[7:0];
        block_bytes[3] = total[15:8];
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, block_bytes.size());
            while (block_bytes.size() > cut)
                void'(block_bytes.pop_back());
        end
    endtask

    task automatic test_keyboard_endpoint();
        block_bytes.delete();
        add_descriptor(9, TYPE_INTERFACE, 8'h20, 8'h00, 8'h01, HID_CLASS, 8'h01, KBD_PROTOCOL,
                       8'h00);
        add_descriptor(7, TYPE_ENDPOINT, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A, 8'h00, 8'h00);
        // trailing bytes after the match are ignored
        block_bytes.push_back(8'($urandom));
        block_bytes.push_back(8'($urandom));
        send_block(1'b1);
    endtask

    task automatic test_short_descriptor();
        block_bytes.delete();
        add_descriptor(9, TYPE_INTERFACE, 8'hFF, 8'h00, 8'h01, HID_CLASS, 8'h01, KBD_PROTOCOL,
                       8'hFF);
        add_descriptor(3, TYPE_ENDPOINT, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        block_bytes.push_back(8'hFF);
        send_block(1'b1);
    endtask

    task automatic test_early_starts();
        // zero length at the first start, total known only at byte 3
        block_bytes.delete();
        block_bytes.push_back(8'h00);
        block_bytes.push_back(8'h00);
        block_bytes.push_back(8'h10);
        block_bytes.push_back(8'h00);
        block_bytes.push_back(8'h00);
        send_block(1'b1);
        // zero length at offset 2 with a zero total: total length wins
        block_bytes.delete();
        block_bytes.push_back(8'h02);
        block_bytes.push_back(8'h00);
        block_bytes.push_back(8'h00);
        block_bytes.push_back(8'h00);
        block_bytes.push_back(8'h00);
        send_block(1'b1);
    endtask

    task automatic test_stream_end();
        send_byte(8'hFF, 1'b1);
        // last byte arrives with an endpoint match pending
        block_bytes.delete();
        add_descriptor(9, TYPE_INTERFACE, 8'h40, 8'h00, 8'h01, HID_CLASS, 8'h01, KBD_PROTOCOL,
                       8'h00);
        add_descriptor(7, TYPE_ENDPOINT, 8'h83, 8'h03, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (2) void'(block_bytes.pop_back());
        send_block(1'b1);
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (12) send_byte(8'($urandom), 1'b1);
    endtask

    task automatic test_random_blocks();
        int n;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    make_config_block();
                    block_bytes[$urandom_range(0, block_bytes.size() - 1)] = 8'($urandom);
                    send_block($urandom_range(0, 9) != 0);
                end
                8, 9:
                begin
                    n = $urandom_range(1, 30);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom), (i == n - 1) ? ($urandom_range(0, 3) != 0)
                                                             : ($urandom_range(0, 19) == 0));
                end
                default:
                begin
                    make_config_block();
                    send_block($urandom_range(0, 9) != 0);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_keyboard_endpoint();
        test_short_descriptor();
        test_early_starts();
        test_stream_end();
        test_backpressure();
        test_random_blocks();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("covered %0d bytes sent, %0d scanned, in %0d blocks plus loose bytes",
                 items_sent, live_items, blocks_sent);
        $display("checked %0d results, %0d keyboard endpoints, %0d mismatches",
                 results_checked, keyboards_found, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/ucds_pkg.sv
src/usb_config_descriptor_scan.sv
tb/testbench.sv
